[hdl/smpq_pkg.sv]
package smpq_pkg;

  // defaults for the top level parameters
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IN_PRIO_W = 8;
  localparam int unsigned FILL_W   = 5;

  // request opcodes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

[hdl/smpq_ifs.sv]
interface smpq_req_if import smpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [DATA_W-1:0]   item_data;
  logic [IN_PRIO_W-1:0]       item_priority;

  modport source (output valid, op, item_data, item_priority, input ready);
  modport sink (input valid, op, item_data, item_priority, output ready);
endinterface

interface smpq_rsp_if import smpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   out_data;
  logic [1:0]                 status;
  logic [FILL_W-1:0]          fill_count;

  modport source (output valid, out_data, status, fill_count, input ready);
  modport sink (input valid, out_data, status, fill_count, output ready);
endinterface

[hdl/smpq_cell.sv]
module smpq_cell import smpq_pkg::*; #(
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic                 occupied,
  input  logic [DATA_W-1:0]    new_data,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 left_stays,
  input  logic [DATA_W-1:0]    left_data,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [DATA_W-1:0]    right_data,
  input  logic [PRIO_BITS-1:0] right_prio,
  output logic                 stays,
  output logic [DATA_W-1:0]    data,
  output logic [PRIO_BITS-1:0] prio
);

  // entry stays put on insert when it sorts at or before the new one
  assign stays = occupied && (prio <= new_prio);

  // insert: keep, take the new entry, or take the left neighbor
  // remove: take the right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.insert && !stays) begin
      if (left_stays) begin
        data <= new_data;
        prio <= new_prio;
      end else begin
        data <= left_data;
        prio <= left_prio;
      end
    end else if (ctrl.remove) begin
      data <= right_data;
      prio <= right_prio;
    end
  end

endmodule

[hdl/stable_min_priority_queue_top.sv]
// stable minimum priority queue built as a row of compare-and-shift cells
// the response is registered when the request is accepted and is valid from the next cycle
// throughput: one request per cycle while responses are taken; every cell compares and shifts in parallel
// a new request is taken only while the output register is empty or being read
// in the same cycle, so a waiting response holds off the next request
// reset: synchronous, clears the entry count and the response valid; cell
// contents are left as they are and never read before being written
module stable_min_priority_queue_top import smpq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  smpq_req_if.sink   req,
  smpq_rsp_if.source rsp
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 full;
  logic                 empty;
  logic                 accept;
  cell_ctrl_t           ctrl;
  logic [PRIO_BITS-1:0] new_prio;
  logic [DATA_W-1:0]    new_data;
  logic [DATA_W-1:0]    resp_data;
  status_t              resp_status;

  logic                 cell_stays [DEPTH];
  logic [DATA_W-1:0]    cell_data  [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio  [DEPTH];

  // handshake: output register frees as soon as it is taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign new_prio = PRIO_BITS'(req.item_priority);
  assign new_data = req.item_data;

  // decode the request into a cell command and a response
  always_comb begin
    ctrl        = '0;
    count_next  = count;
    resp_data   = '0;
    resp_status = ST_ENQ;
    case (op_t'(req.op))
      OP_DEQ: begin
        if (empty) begin
          resp_status = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          resp_data   = cell_data[0];
          resp_status = ST_DEQ;
          count_next  = count - CNT_W'(1);
        end
      end
      OP_ENQ: begin
        if (full) begin
          resp_status = ST_FULL;
        end else begin
          ctrl.insert = accept;
          resp_status = ST_ENQ;
          count_next  = count + CNT_W'(1);
        end
      end
      default: begin
        resp_status = ST_ENQ;
      end
    endcase
  end

  // cell row, slot 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 occ;
    logic                 l_stays;
    logic [DATA_W-1:0]    l_data;
    logic [PRIO_BITS-1:0] l_prio;
    logic [DATA_W-1:0]    r_data;
    logic [PRIO_BITS-1:0] r_prio;

    assign occ = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_stays = 1'b1;
      assign l_data  = new_data;
      assign l_prio  = new_prio;
    end else begin : g_mid
      assign l_stays = cell_stays[i-1];
      assign l_data  = cell_data[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    smpq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .new_data  (new_data),
      .new_prio  (new_prio),
      .left_stays(l_stays),
      .left_data (l_data),
      .left_prio (l_prio),
      .right_data(r_data),
      .right_prio(r_prio),
      .stays     (cell_stays[i]),
      .data      (cell_data[i]),
      .prio      (cell_prio[i])
    );
  end

  // entry count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_data   <= resp_data;
      rsp.status     <= resp_status;
      rsp.fill_count <= FILL_W'(count_next);
    end
  end

endmodule
